// ===== sv/lfpd_pkg.sv =====
// Package for line_follow_pid_drive: constants, register codes, stage payload types.
// Depends on nothing; every other file of the block but lfpd_checker uses it by scoped names.
`default_nettype none
package lfpd_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int LEVEL_INPUTS = 8;
    localparam int LANE_COUNT   = (SENSOR_COUNT > LEVEL_INPUTS) ? LEVEL_INPUTS : SENSOR_COUNT;

    localparam int POS_W   = 13;
    localparam int LEVEL_W = 10;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 8;
    localparam int ERR_W   = 13;
    localparam int DERIV_W = 14;
    localparam int INTEG_W = 18;
    localparam int ACC_W   = 21;
    localparam int SUM_W   = 40;
    localparam int QUO_W   = 24;
    localparam int CORR_W  = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0]           POS_MAX       = 13'd7000;
    localparam logic signed [DERIV_W-1:0]  CENTER_POS    = 14'sd3500;
    localparam logic signed [ACC_W-1:0]    INTEG_LIMIT   = 21'sd128000;
    localparam logic signed [26:0]         DECAY_NUM     = 27'sd205;
    localparam logic signed [26:0]         DECAY_BIAS    = 27'sd255;
    localparam logic signed [SUM_W-1:0]    QUO_BIAS      = 40'sd65535;
    localparam logic [SPEED_W-1:0]         THIRD_MUL     = 8'd171;
    localparam logic [SPEED_W-1:0]         DRIVE_MAX     = 8'd255;

    localparam logic [GAIN_W-1:0]    KP_RESET  = 16'd0;
    localparam logic [GAIN_W-1:0]    KI_RESET  = 16'd0;
    localparam logic [GAIN_W-1:0]    KD_RESET  = 16'd0;
    localparam logic [SPEED_W-1:0]   TOP_RESET = 8'd200;
    localparam logic [LEVEL_W-1:0]   THR_RESET = 10'd500;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KP_GAIN        = 3'd0,
        REG_KI_GAIN        = 3'd1,
        REG_KD_GAIN        = 3'd2,
        REG_TOP_SPEED      = 3'd3,
        REG_DARK_THRESHOLD = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_gain;
        logic [GAIN_W-1:0]  ki_gain;
        logic [GAIN_W-1:0]  kd_gain;
        logic [SPEED_W-1:0] top_speed;
        logic [LEVEL_W-1:0] dark_threshold;
    } cfg_t;

    typedef struct packed {
        logic                       lost;
        logic signed [ERR_W-1:0]    err;
        logic signed [DERIV_W-1:0]  deriv;
        logic signed [INTEG_W-1:0]  integ;
    } s1_t;

    typedef struct packed {
        logic               lost;
        logic signed [29:0] p_kp;
        logic signed [34:0] p_ki;
        logic signed [30:0] p_kd;
    } s2_t;

    typedef struct packed {
        logic                    lost;
        logic signed [SUM_W-1:0] sum;
    } s3_t;

endpackage
`default_nettype wire

// ===== sv/lfpd_if.sv =====
// Channel interfaces for line_follow_pid_drive: sample input, drive output, config write.
// Depends on lfpd_pkg for field widths.
`default_nettype none
interface lfpd_samp_if;
    logic                              valid;
    logic                              ready;
    logic [lfpd_pkg::POS_W-1:0]        line_position;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_0;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_1;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_2;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_3;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_4;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_5;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_6;
    logic [lfpd_pkg::LEVEL_W-1:0]      level_7;
    modport source (output valid, line_position, level_0, level_1, level_2, level_3,
                    level_4, level_5, level_6, level_7, input ready);
    modport sink   (input valid, line_position, level_0, level_1, level_2, level_3,
                    level_4, level_5, level_6, level_7, output ready);
endinterface

interface lfpd_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [lfpd_pkg::SPEED_W-1:0]      left_drive;
    logic [lfpd_pkg::SPEED_W-1:0]      right_drive;
    logic                              line_lost;
    modport source (output valid, left_drive, right_drive, line_lost, input ready);
    modport sink   (input valid, left_drive, right_drive, line_lost, output ready);
endinterface

interface lfpd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lfpd_pkg::CFG_ADDR_W-1:0]   addr;
    logic [lfpd_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== sv/lfpd_lane.sv =====
// One sensor lane: tests a reflectance level against the dark threshold.
// Depends on lfpd_pkg.
`default_nettype none
module lfpd_lane (
    input  wire logic [lfpd_pkg::LEVEL_W-1:0] level,
    input  wire logic [lfpd_pkg::LEVEL_W-1:0] threshold,
    output logic                              hit
);
    assign hit = (level > threshold);
endmodule
`default_nettype wire

// ===== sv/lfpd_state.sv =====
// Lane merge and controller state: error, derivative, clamped or decayed integral.
// Depends on lfpd_pkg; feeds the first pipeline register (s1_t).
`default_nettype none
module lfpd_state (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic [lfpd_pkg::LANE_COUNT-1:0]   hits,
    input  wire logic [lfpd_pkg::POS_W-1:0]        position,
    output lfpd_pkg::s1_t                          s1
);
    logic signed [lfpd_pkg::INTEG_W-1:0] integ_reg;
    logic signed [lfpd_pkg::INTEG_W-1:0] integ_next;
    logic signed [lfpd_pkg::ERR_W-1:0]   prev_err_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]   prev_err_next;
    lfpd_pkg::s1_t                       s1_reg;
    lfpd_pkg::s1_t                       s1_next;

    logic                                seen;
    logic [lfpd_pkg::POS_W-1:0]          pos_c;
    logic signed [lfpd_pkg::DERIV_W-1:0] err_w;
    logic signed [lfpd_pkg::ERR_W-1:0]   err;
    logic signed [lfpd_pkg::DERIV_W-1:0] deriv;
    logic signed [lfpd_pkg::ACC_W-1:0]   acc;
    logic signed [lfpd_pkg::INTEG_W-1:0] acc_c;
    logic signed [26:0]                  dprod;
    logic signed [26:0]                  dbias;
    logic signed [26:0]                  dshift;

    always_comb
    begin
        seen  = |hits;
        pos_c = (position > lfpd_pkg::POS_MAX) ? lfpd_pkg::POS_MAX : position;
        err_w = $signed({1'b0, pos_c}) - lfpd_pkg::CENTER_POS;
        err   = err_w[lfpd_pkg::ERR_W-1:0];
        deriv = $signed({err[lfpd_pkg::ERR_W-1], err})
              - $signed({prev_err_reg[lfpd_pkg::ERR_W-1], prev_err_reg});
        acc   = $signed({{(lfpd_pkg::ACC_W-lfpd_pkg::INTEG_W){integ_reg[lfpd_pkg::INTEG_W-1]}},
                         integ_reg})
              + $signed({err, 8'b0});
        if (acc > lfpd_pkg::INTEG_LIMIT)
        begin
            acc_c = lfpd_pkg::INTEG_LIMIT[lfpd_pkg::INTEG_W-1:0];
        end
        else if (acc < -lfpd_pkg::INTEG_LIMIT)
        begin
            acc_c = -lfpd_pkg::INTEG_LIMIT[lfpd_pkg::INTEG_W-1:0];
        end
        else
        begin
            acc_c = acc[lfpd_pkg::INTEG_W-1:0];
        end
        dprod  = $signed({{(27-lfpd_pkg::INTEG_W){integ_reg[lfpd_pkg::INTEG_W-1]}}, integ_reg})
               * lfpd_pkg::DECAY_NUM;
        dbias  = dprod + (dprod[26] ? lfpd_pkg::DECAY_BIAS : 27'sd0);
        dshift = dbias >>> 8;

        if (seen)
        begin
            integ_next    = acc_c;
            prev_err_next = err;
        end
        else
        begin
            integ_next    = dshift[lfpd_pkg::INTEG_W-1:0];
            prev_err_next = prev_err_reg;
        end
        s1_next.lost  = !seen;
        s1_next.err   = err;
        s1_next.deriv = deriv;
        s1_next.integ = integ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (load)
        begin
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;
endmodule
`default_nettype wire

// ===== sv/lfpd_mac.sv =====
// Gain multipliers and the PID sum, two pipeline stages.
// Depends on lfpd_pkg; takes s1_t, delivers s3_t.
`default_nettype none
module lfpd_mac (
    input  wire logic              clk,
    input  wire logic              load_mul,
    input  wire logic              load_sum,
    input  wire lfpd_pkg::cfg_t    cfg_regs,
    input  wire lfpd_pkg::s1_t     s1,
    output lfpd_pkg::s3_t          s3
);
    lfpd_pkg::s2_t s2_reg;
    lfpd_pkg::s2_t s2_next;
    lfpd_pkg::s3_t s3_reg;
    lfpd_pkg::s3_t s3_next;

    logic signed [lfpd_pkg::GAIN_W:0]    kp_s;
    logic signed [lfpd_pkg::GAIN_W:0]    ki_s;
    logic signed [lfpd_pkg::GAIN_W:0]    kd_s;
    logic signed [lfpd_pkg::SUM_W-1:0]   t_kp;
    logic signed [lfpd_pkg::SUM_W-1:0]   t_ki;
    logic signed [lfpd_pkg::SUM_W-1:0]   t_kd;

    always_comb
    begin
        kp_s = $signed({1'b0, cfg_regs.kp_gain});
        ki_s = $signed({1'b0, cfg_regs.ki_gain});
        kd_s = $signed({1'b0, cfg_regs.kd_gain});
        s2_next.lost = s1.lost;
        s2_next.p_kp = 30'(kp_s) * 30'(s1.err);
        s2_next.p_ki = 35'(ki_s) * 35'(s1.integ);
        s2_next.p_kd = 31'(kd_s) * 31'(s1.deriv);
    end

    always_comb
    begin
        t_kp = $signed({{2{s2_reg.p_kp[29]}}, s2_reg.p_kp, 8'b0});
        t_ki = $signed({{5{s2_reg.p_ki[34]}}, s2_reg.p_ki});
        t_kd = $signed({s2_reg.p_kd[30], s2_reg.p_kd, 8'b0});
        s3_next.lost = s2_reg.lost;
        s3_next.sum  = t_kp + t_ki + t_kd;
    end

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            s2_reg <= s2_next;
        end
        if (load_sum)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;
endmodule
`default_nettype wire

// ===== sv/lfpd_mix.sv =====
// Correction scaling and clamp, then base speed and left/right drive saturation.
// Depends on lfpd_pkg; takes s3_t, holds the output register.
`default_nettype none
module lfpd_mix (
    input  wire logic                              clk,
    input  wire logic                              load_corr,
    input  wire logic                              load_out,
    input  wire lfpd_pkg::cfg_t                    cfg_regs,
    input  wire lfpd_pkg::s3_t                     s3,
    output logic [lfpd_pkg::SPEED_W-1:0]           left_drive,
    output logic [lfpd_pkg::SPEED_W-1:0]           right_drive,
    output logic                                   line_lost
);
    logic signed [lfpd_pkg::CORR_W-1:0] corr_reg;
    logic signed [lfpd_pkg::CORR_W-1:0] corr_next;
    logic                               lost4_reg;
    logic [lfpd_pkg::SPEED_W-1:0]       left_reg;
    logic [lfpd_pkg::SPEED_W-1:0]       left_next;
    logic [lfpd_pkg::SPEED_W-1:0]       right_reg;
    logic [lfpd_pkg::SPEED_W-1:0]       right_next;
    logic                               lost_reg;

    logic signed [lfpd_pkg::SUM_W-1:0]  biased;
    logic signed [lfpd_pkg::SUM_W-1:0]  quo_w;
    logic signed [lfpd_pkg::QUO_W-1:0]  quo;
    logic signed [lfpd_pkg::QUO_W-1:0]  top_q;
    logic [lfpd_pkg::SPEED_W-1:0]       acorr;
    logic [lfpd_pkg::SPEED_W-1:0]       base0;
    logic [15:0]                        tprod;
    logic [lfpd_pkg::SPEED_W-1:0]       third;
    logic [lfpd_pkg::SPEED_W-1:0]       base;
    logic signed [9:0]                  lsum;
    logic signed [9:0]                  rsum;

    always_comb
    begin
        biased = s3.sum + (s3.sum[lfpd_pkg::SUM_W-1] ? lfpd_pkg::QUO_BIAS : 40'sd0);
        quo_w  = biased >>> 16;
        quo    = quo_w[lfpd_pkg::QUO_W-1:0];
        top_q  = $signed({{(lfpd_pkg::QUO_W-lfpd_pkg::SPEED_W){1'b0}}, cfg_regs.top_speed});
        if (quo > top_q)
        begin
            corr_next = $signed({1'b0, cfg_regs.top_speed});
        end
        else if (quo < -top_q)
        begin
            corr_next = -$signed({1'b0, cfg_regs.top_speed});
        end
        else
        begin
            corr_next = quo[lfpd_pkg::CORR_W-1:0];
        end
    end

    always_comb
    begin
        acorr = corr_reg[lfpd_pkg::CORR_W-1] ? 8'(-corr_reg) : corr_reg[lfpd_pkg::SPEED_W-1:0];
        base0 = cfg_regs.top_speed - {1'b0, acorr[lfpd_pkg::SPEED_W-1:1]};
        tprod = 16'(cfg_regs.top_speed) * 16'(lfpd_pkg::THIRD_MUL);
        third = {1'b0, tprod[15:9]};
        base  = (base0 < third) ? third : base0;
        lsum  = $signed({2'b0, base}) + $signed({corr_reg[lfpd_pkg::CORR_W-1], corr_reg});
        rsum  = $signed({2'b0, base}) - $signed({corr_reg[lfpd_pkg::CORR_W-1], corr_reg});
        if (lost4_reg)
        begin
            left_next  = '0;
            right_next = '0;
        end
        else
        begin
            left_next  = lsum[9] ? 8'd0 : (lsum[8] ? lfpd_pkg::DRIVE_MAX : lsum[7:0]);
            right_next = rsum[9] ? 8'd0 : (rsum[8] ? lfpd_pkg::DRIVE_MAX : rsum[7:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_corr)
        begin
            corr_reg  <= corr_next;
            lost4_reg <= s3.lost;
        end
        if (load_out)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            lost_reg  <= lost4_reg;
        end
    end

    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign line_lost   = lost_reg;
endmodule
`default_nettype wire

// ===== sv/line_follow_pid_drive.sv =====
// Top level of line_follow_pid_drive: config registers, sensor lanes, pipeline control.
// Depends on lfpd_pkg, lfpd_if, lfpd_lane, lfpd_state, lfpd_mac, lfpd_mix.
//
// Channels: samp carries one sample (line_position and level_0..level_7), cmd returns
// left_drive, right_drive and line_lost, cfg writes kp_gain, ki_gain, kd_gain, top_speed
// and dark_threshold at indexes 0..4; other indexes are dropped. cfg.ready is always high.
// Each channel transfers at a rising edge with valid and ready high.
// A sample passes the s1, s2, s3, correction and output registers before it shows on cmd.
// Throughput: one sample per cycle while cmd does not stall. The integral and previous error update in the
// cycle the sample transfers, so consecutive samples need no gap; the five-stage
// pipeline (lane test and state, gain multiply, sum, correction, drive) sets latency.
// The LANE_COUNT lanes test their levels in parallel and an OR merges the hits.
// Reset clears the integral, previous error, stage valid bits and loads register
// defaults (gains 0, top_speed 200, dark_threshold 500).
// When cmd stalls, the result holds in the output register and stages fill behind
// it; samp.ready drops only once all five stages hold a sample.
`default_nettype none
module line_follow_pid_drive (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfpd_samp_if.sink  samp,
    lfpd_cmd_if.source cmd,
    lfpd_cfg_if.sink   cfg
);
    lfpd_pkg::cfg_t cfg_reg;
    lfpd_pkg::cfg_t cfg_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    logic [lfpd_pkg::LEVEL_W-1:0]    level_arr [lfpd_pkg::LEVEL_INPUTS];
    logic [lfpd_pkg::LANE_COUNT-1:0] hits;
    lfpd_pkg::s1_t                   s1;
    lfpd_pkg::s3_t                   s3;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                lfpd_pkg::REG_KP_GAIN:        cfg_next.kp_gain        = cfg.data;
                lfpd_pkg::REG_KI_GAIN:        cfg_next.ki_gain        = cfg.data;
                lfpd_pkg::REG_KD_GAIN:        cfg_next.kd_gain        = cfg.data;
                lfpd_pkg::REG_TOP_SPEED:      cfg_next.top_speed      = cfg.data[7:0];
                lfpd_pkg::REG_DARK_THRESHOLD: cfg_next.dark_threshold = cfg.data[9:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain        <= lfpd_pkg::KP_RESET;
            cfg_reg.ki_gain        <= lfpd_pkg::KI_RESET;
            cfg_reg.kd_gain        <= lfpd_pkg::KD_RESET;
            cfg_reg.top_speed      <= lfpd_pkg::TOP_RESET;
            cfg_reg.dark_threshold <= lfpd_pkg::THR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;

    assign en5 = !v5_reg || cmd.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign samp.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= samp.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    assign level_arr[0] = samp.level_0;
    assign level_arr[1] = samp.level_1;
    assign level_arr[2] = samp.level_2;
    assign level_arr[3] = samp.level_3;
    assign level_arr[4] = samp.level_4;
    assign level_arr[5] = samp.level_5;
    assign level_arr[6] = samp.level_6;
    assign level_arr[7] = samp.level_7;

    for (genvar i = 0; i < lfpd_pkg::LANE_COUNT; i++)
    begin : g_lane
        lfpd_lane u_lane (
            .level     (level_arr[i]),
            .threshold (cfg_reg.dark_threshold),
            .hit       (hits[i])
        );
    end

    lfpd_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (samp.valid && en1),
        .hits     (hits),
        .position (samp.line_position),
        .s1       (s1)
    );

    lfpd_mac u_mac (
        .clk      (clk),
        .load_mul (v1_reg && en2),
        .load_sum (v2_reg && en3),
        .cfg_regs (cfg_reg),
        .s1       (s1),
        .s3       (s3)
    );

    lfpd_mix u_mix (
        .clk         (clk),
        .load_corr   (v3_reg && en4),
        .load_out    (v4_reg && en5),
        .cfg_regs    (cfg_reg),
        .s3          (s3),
        .left_drive  (cmd.left_drive),
        .right_drive (cmd.right_drive),
        .line_lost   (cmd.line_lost)
    );

    assign cmd.valid = v5_reg;
endmodule
`default_nettype wire

// ===== sv/lfpd_checker.sv =====
// Port-level checks for line_follow_pid_drive, attached by bind.
// Depends on the top level's channel ports only.
`default_nettype none
module lfpd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       samp_ready,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic [7:0] left_drive,
    input wire logic [7:0] right_drive,
    input wire logic       line_lost
);
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(left_drive)
            && $stable(right_drive) && $stable(line_lost))
        else $error("cmd payload changed under stall");

    a_lost_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && line_lost |-> left_drive == 8'd0 && right_drive == 8'd0)
        else $error("drives not stopped on lost line");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !samp_ready |-> cmd_valid && !cmd_ready)
        else $error("samp stalled while cmd is not stalled");

    a_lost_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready && line_lost |=> line_lost)
        else $error("line_lost dropped under stall");
endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .samp_ready  (samp.ready),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .left_drive  (cmd.left_drive),
    .right_drive (cmd.right_drive),
    .line_lost   (cmd.line_lost)
);
`default_nettype wire
